// File: rtl/fdss_pkg.sv
// Shared types, constants and decode tables for the four-digit display frame generator.
// Used by fdss_digit_split, fdss_frame_seq and four_digit_seven_segment_frames.
package fdss_pkg;

  localparam int VALUE_W     = 14;
  localparam int NUM_DIGITS  = 4;
  localparam int NUM_FRAMES  = 2 * NUM_DIGITS;
  localparam int FRAME_CNT_W = $clog2(NUM_FRAMES);

  localparam logic [VALUE_W-1:0] MAX_VALUE = 14'd9999;

  localparam logic [7:0] POINT_BIT      = 8'h80;
  localparam logic [7:0] BLANK_SELECT   = 8'h00;
  localparam logic [7:0] BLANK_SEGMENTS = 8'h00;
  localparam logic [1:0] POINT_DIGIT    = 2'd1;

  localparam logic [FRAME_CNT_W-1:0] LAST_FRAME = FRAME_CNT_W'(NUM_FRAMES - 1);

  // Segment bytes for the four digits, thousands in entry 0.
  typedef logic [NUM_DIGITS-1:0][7:0] seg_set_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = BLANK_SEGMENTS;
    endcase
    return pat;
  endfunction

  // Active-low digit enables, first digit in position 0.
  function automatic logic [7:0] select_code(input logic [1:0] digit);
    logic [7:0] code;
    case (digit)
      2'd0:    code = 8'h0E;
      2'd1:    code = 8'h0D;
      2'd2:    code = 8'h0B;
      2'd3:    code = 8'h07;
      default: code = BLANK_SELECT;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/fdss_digit_split.sv
// Input register, saturation, decimal digit split and segment decode.
// Depends on fdss_pkg.
module fdss_digit_split (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fdss_pkg::VALUE_W-1:0]  in_value,
  input  logic                          in_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fdss_pkg::seg_set_t            out_segs
);

  logic                         a_valid;
  logic [fdss_pkg::VALUE_W-1:0] a_value;
  logic                         a_point;
  logic                         b_valid;
  fdss_pkg::seg_set_t           b_segs;
  logic                         b_load;
  fdss_pkg::seg_set_t           segs_next;

  assign b_load   = a_valid && (!b_valid || out_ready);
  assign in_ready = !a_valid || b_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (b_load) begin
      a_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      a_value <= in_value;
      a_point <= in_point;
    end
  end

  // Each digit is found by comparing against all its multiples in parallel,
  // then subtracting the largest one that fits.
  always_comb begin
    logic [fdss_pkg::VALUE_W-1:0] sat;
    logic [fdss_pkg::VALUE_W-1:0] r1;
    logic [9:0]                   r2;
    logic [6:0]                   r3;
    logic [3:0]                   d_th;
    logic [3:0]                   d_hu;
    logic [3:0]                   d_te;
    sat  = (a_value > fdss_pkg::MAX_VALUE) ? fdss_pkg::MAX_VALUE : a_value;
    d_th = 4'd0;
    r1   = sat;
    for (int k = 1; k < 10; k++) begin
      if (sat >= 14'(k * 1000)) begin
        d_th = 4'(k);
        r1   = sat - 14'(k * 1000);
      end
    end
    d_hu = 4'd0;
    r2   = r1[9:0];
    for (int k = 1; k < 10; k++) begin
      if (r1[9:0] >= 10'(k * 100)) begin
        d_hu = 4'(k);
        r2   = r1[9:0] - 10'(k * 100);
      end
    end
    d_te = 4'd0;
    r3   = r2[6:0];
    for (int k = 1; k < 10; k++) begin
      if (r2[6:0] >= 7'(k * 10)) begin
        d_te = 4'(k);
        r3   = r2[6:0] - 7'(k * 10);
      end
    end
    segs_next[0] = fdss_pkg::seg_pattern(d_th);
    segs_next[1] = fdss_pkg::seg_pattern(d_hu) | (a_point ? fdss_pkg::POINT_BIT : 8'h00);
    segs_next[2] = fdss_pkg::seg_pattern(d_te);
    segs_next[3] = fdss_pkg::seg_pattern(r3[3:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= 1'b1;
    end else if (out_ready) begin
      b_valid <= 1'b0;
    end
    if (b_load) begin
      b_segs <= segs_next;
    end
  end

  assign out_valid = b_valid;
  assign out_segs  = b_segs;

endmodule

// File: rtl/fdss_frame_seq.sv
// Frame sequencer: walks the eight frames of one value into the output register.
// Depends on fdss_pkg.
module fdss_frame_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               common_anode,
  input  logic               in_valid,
  output logic               in_ready,
  input  fdss_pkg::seg_set_t in_segs,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_select,
  output logic [7:0]         out_segments,
  output logic               out_last
);

  logic                             busy;
  fdss_pkg::seg_set_t               segs;
  logic [fdss_pkg::FRAME_CNT_W-1:0] cnt;
  logic                             o_load;
  logic [7:0]                       sel_next;
  logic [7:0]                       seg_next;

  assign o_load   = busy && (!out_valid || out_ready);
  assign in_ready = !busy || (o_load && cnt == fdss_pkg::LAST_FRAME);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (o_load) begin
      cnt <= cnt + 1'b1;
      if (cnt == fdss_pkg::LAST_FRAME) begin
        busy <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      segs <= in_segs;
    end
  end

  // Even frames blank the display, odd frames drive the digit in cnt[2:1].
  always_comb begin
    if (cnt[0]) begin
      sel_next = fdss_pkg::select_code(cnt[2:1]);
      seg_next = segs[cnt[2:1]];
    end else begin
      sel_next = fdss_pkg::BLANK_SELECT;
      seg_next = fdss_pkg::BLANK_SEGMENTS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (o_load) begin
      out_select   <= common_anode ? ~sel_next : sel_next;
      out_segments <= common_anode ? ~seg_next : seg_next;
      out_last     <= (cnt == fdss_pkg::LAST_FRAME);
    end
  end

endmodule

// File: rtl/four_digit_seven_segment_frames.sv
// Four-digit seven-segment frame generator, top level.
// An input value passes the input register and segment register before the frame sequencer.
// Throughput: eight frames per value, one frame per cycle while m_tready stays high;
// the frame sequencer's output register sets that pace.
// Reset (rst, synchronous) empties all stages and clears common_anode.
// Depends on fdss_pkg, fdss_digit_split and fdss_frame_seq.
module four_digit_seven_segment_frames (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,      // value [13:0], decimal_point [14], zero [15]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // digit_select [7:0], segments [15:8]
  output logic        m_tlast,      // last_frame
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data   // common_anode
);

  logic               common_anode;
  logic               mid_valid;
  logic               mid_ready;
  fdss_pkg::seg_set_t mid_segs;
  logic [7:0]         frame_select;
  logic [7:0]         frame_segments;

  always_ff @(posedge clk) begin
    if (rst) begin
      common_anode <= 1'b0;
    end else if (cfg_wr_en) begin
      common_anode <= cfg_wr_data;
    end
  end

  fdss_digit_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_value  (s_tdata[fdss_pkg::VALUE_W-1:0]),
    .in_point  (s_tdata[fdss_pkg::VALUE_W]),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_segs  (mid_segs)
  );

  fdss_frame_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .common_anode (common_anode),
    .in_valid     (mid_valid),
    .in_ready     (mid_ready),
    .in_segs      (mid_segs),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_select   (frame_select),
    .out_segments (frame_segments),
    .out_last     (m_tlast)
  );

  assign m_tdata = {frame_segments, frame_select};

  // Within a value the frames follow without gaps.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("frame sequence broke off before the last frame");

  // The last frame always drives the fourth digit.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |->
      m_tdata[7:0] == (common_anode ? ~fdss_pkg::select_code(2'd3)
                                    : fdss_pkg::select_code(2'd3)))
    else $error("last frame does not select the fourth digit");

  // A blanking frame never carries the last flag.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[7:0] == (common_anode ? ~fdss_pkg::BLANK_SELECT
                                                : fdss_pkg::BLANK_SELECT)) |-> !m_tlast)
    else $error("blanking frame flagged as last");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for four_digit_seven_segment_frames.
// Predicts the eight display frames of each value and compares every output transaction.
// Depends on fdss_pkg and the RTL of the frame generator.
`timescale 1ns / 100ps

module testbench;

  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 10;
  localparam int POINT_POS    = 1;

  localparam logic [7:0] GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [7:0] DIGIT_ENABLE [4] = '{8'h0E, 8'h0D, 8'h0B, 8'h07};

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segments;
    logic       last_frame;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  frame_t pending_frames [$];
  frame_t expected_frame;
  logic   anode_mode = 1'b0;
  bit     full_rate = 1'b0;
  int     mismatch_count = 0;
  int     idle_cycles = 0;

  four_digit_seven_segment_frames dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [13:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 14'($urandom_range(0, 9999));
    if (roll < 70) return 14'($urandom_range(10000, 16383));
    if (roll < 80) return 14'($urandom_range(9990, 10010));
    return 14'($urandom_range(0, 120));
  endfunction

  function automatic frame_t make_frame(input logic [7:0] sel, input logic [7:0] seg,
                                        input logic last);
    frame_t f;
    f.digit_select = anode_mode ? ~sel : sel;
    f.segments     = anode_mode ? ~seg : seg;
    f.last_frame   = last;
    return f;
  endfunction

  // Each value becomes a blanking frame and a digit frame per digit, thousands first.
  task automatic predict_frames(input logic [13:0] value, input logic dp);
    int         shown;
    logic [3:0] digit [4];
    logic [7:0] seg;
    shown = (value > fdss_pkg::MAX_VALUE) ? int'(fdss_pkg::MAX_VALUE) : int'(value);
    digit[0] = 4'(shown / 1000);
    digit[1] = 4'((shown / 100) % 10);
    digit[2] = 4'((shown / 10) % 10);
    digit[3] = 4'(shown % 10);
    for (int d = 0; d < 4; d++) begin
      seg = GLYPH[digit[d]];
      if (d == POINT_POS && dp) begin
        seg = seg | fdss_pkg::POINT_BIT;
      end
      pending_frames.push_back(make_frame(fdss_pkg::BLANK_SELECT,
                                          fdss_pkg::BLANK_SEGMENTS, 1'b0));
      pending_frames.push_back(make_frame(DIGIT_ENABLE[d], seg, d == 3));
    end
  endtask

  task automatic send_value(input logic [13:0] value, input logic dp);
    int gap;
    gap = full_rate ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, dp, value};
    do @(posedge clk); while (!s_tready);
    predict_frames(value, dp);
  endtask

  // Drops valid, then waits for every predicted frame plus the pipeline latency.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_common_anode(input logic mode);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    anode_mode = mode;
  endtask

  // Field extremes, every digit 0 to 9, saturation and the point.
  task automatic test_reset_defaults();
    send_value(14'd0, 1'b0);
    send_value(14'd0, 1'b1);
    send_value(14'd1, 1'b0);
    send_value(14'd9, 1'b1);
    send_value(14'd10, 1'b0);
    send_value(14'd99, 1'b1);
    send_value(14'd100, 1'b0);
    send_value(14'd999, 1'b1);
    send_value(14'd1000, 1'b0);
    send_value(14'd1234, 1'b1);
    send_value(14'd5678, 1'b0);
    send_value(14'd9999, 1'b1);
    send_value(14'd10000, 1'b0);
    send_value(14'd16383, 1'b1);
  endtask

  task automatic test_common_anode();
    write_common_anode(1'b1);
    send_value(14'd0, 1'b0);
    send_value(14'd8888, 1'b1);
    send_value(14'd16383, 1'b0);
    send_value(14'd4090, 1'b1);
    write_common_anode(1'b0);
  endtask

  // No gaps on either side, so frames stream at full rate across value boundaries.
  task automatic test_back_to_back();
    full_rate = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_value(pick_value(), 1'($urandom_range(0, 1)));
    end
    wait_drained();
    full_rate = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [1:0] mode_plan [4];
    mode_plan = '{2'd1, 2'd0, 2'd2, 2'd2};
    foreach (mode_plan[p]) begin
      write_common_anode(mode_plan[p] == 2'd2 ? 1'($urandom_range(0, 1)) : mode_plan[p][0]);
      for (int i = 0; i < 33; i++) begin
        send_value(pick_value(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 19) == 0) begin
          wait_drained();
        end
      end
    end
  endtask

  // Ready runs high for a random stretch, then stalls unless full rate is asked for.
  initial begin
    int ready_run;
    int ready_hold;
    forever begin
      ready_run = $urandom_range(1, 30);
      repeat (ready_run) begin
        @(negedge clk);
        m_tready <= 1'b1;
      end
      ready_hold = full_rate ? 0 : pick_gap();
      repeat (ready_hold) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: digit_select %h segments %h last_frame %b",
               m_tdata[7:0], m_tdata[15:8], m_tlast);
        mismatch_count++;
      end else begin
        expected_frame = pending_frames.pop_front();
        if (m_tdata[7:0] !== expected_frame.digit_select) begin
          $error("digit_select expected %h actual %h",
                 expected_frame.digit_select, m_tdata[7:0]);
          mismatch_count++;
        end
        if (m_tdata[15:8] !== expected_frame.segments) begin
          $error("segments expected %h actual %h", expected_frame.segments, m_tdata[15:8]);
          mismatch_count++;
        end
        if (m_tlast !== expected_frame.last_frame) begin
          $error("last_frame expected %b actual %b", expected_frame.last_frame, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Stops a hung run: counts cycles without any transaction or register write.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_common_anode();
    test_back_to_back();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_frames.size() != 0) begin
      $error("%0d frames never arrived", pending_frames.size());
    end
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fdss_pkg.sv
rtl/fdss_digit_split.sv
rtl/fdss_frame_seq.sv
rtl/four_digit_seven_segment_frames.sv
verif/testbench.sv
